// ----- rtl/core/oahs_pkg.sv -----
package oahs_pkg;

    localparam int MAX_SLOTS_DEF = 64;
    localparam int KEY_W = 31;
    localparam int CFG_W = 7;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_CLEARED   = 3'd4;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] key_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] slot_index;
    } out_item_t;

endpackage

// ----- rtl/core/oahs_ram.sv -----
module oahs_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/open_addressing_hash_set_core.sv -----
// open-addressing hash set with double hashing
// in channel (in_valid/in_ready) carries one beat per operation: insert, lookup
// or clear; out channel (out_valid/out_ready) returns one beat per operation
// with a status and a slot index.
// one operation at a time: in_ready is high only when the core is idle.
// the two remainders (key mod size, key mod size-5) come from one shared
// restoring divider unit, one quotient bit a cycle, one pass per remainder.
// each probe then goes through slot address (S_ADDR), then registered ram
// read and compare (S_CMP), then S_NEXT for the next slot; at most size probes.
// a clear or an unused kind gives its result in the cycle after accept.
// result is held in an output register until out_ready; no new beat is taken
// while it waits.
// reset: valid marks cleared at once (flip-flops), table_size = 17; the key
// memory is not cleared. writing table_size also clears all valid marks.
module open_addressing_hash_set_core
#(
    parameter int MAX_SLOTS = oahs_pkg::MAX_SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [6:0]            cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  oahs_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output oahs_pkg::out_item_t   out_data
);
    import oahs_pkg::*;

    localparam int AW = $clog2(MAX_SLOTS);
    localparam int SW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_ADDR  = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_NEXT  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CFG_W-1:0] size_cfg_reg;
    logic [MAX_SLOTS-1:0] valid_reg;
    logic [1:0]       kind_reg;
    logic [KEY_W-1:0] key_reg;
    logic [SW-1:0]    size_reg;
    logic [SW-1:0]    rem_reg;
    logic [KEY_W-1:0] quo_reg;
    logic [5:0]       bit_cnt_reg;
    logic             pass_reg;
    logic [SW-1:0]    step_reg;
    logic [SW-1:0]    slot_reg;
    logic [SW-1:0]    probe_reg;
    logic [SW-1:0]    inc_reg;
    out_item_t        res_reg;

    logic [SW-1:0] eff_size;
    logic [SW-1:0] divisor;
    logic [SW:0]   trial;
    logic [SW:0]   sum_w;
    logic [KEY_W-1:0] rd_key;
    logic          ram_we;

    always_comb
    begin
        if (SW'(size_cfg_reg) < SW'(6))
            eff_size = SW'(6);
        else if (SW'(size_cfg_reg) > SW'(MAX_SLOTS))
            eff_size = SW'(MAX_SLOTS);
        else
            eff_size = SW'(size_cfg_reg);
    end

    assign divisor = pass_reg ? size_reg : size_reg - SW'(5);
    assign trial   = {rem_reg, quo_reg[KEY_W-1]};
    assign sum_w   = {1'b0, slot_reg} + {1'b0, inc_reg};
    assign ram_we  = (state_reg == S_CMP) && (kind_reg == KIND_INSERT)
                     && !valid_reg[slot_reg[AW-1:0]];

    oahs_ram #(.WIDTH(KEY_W), .DEPTH(MAX_SLOTS)) u_keys (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg[AW-1:0]),
        .wdata (key_reg),
        .raddr (slot_reg[AW-1:0]),
        .rdata (rd_key)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    if (in_data.kind == KIND_INSERT || in_data.kind == KIND_LOOKUP)
                        state_next = S_DIV;
                    else
                        state_next = S_OUT;
                end
            S_DIV:
                if (bit_cnt_reg == 6'd0 && pass_reg)
                    state_next = S_ADDR;
            S_ADDR:
                state_next = S_CMP;
            S_CMP:
            begin
                if (!valid_reg[slot_reg[AW-1:0]])
                    state_next = S_OUT;
                else if (kind_reg == KIND_LOOKUP && rd_key == key_reg)
                    state_next = S_OUT;
                else if (probe_reg + SW'(1) >= size_reg)
                    state_next = S_OUT;
                else
                    state_next = S_NEXT;
            end
            S_NEXT:
                state_next = S_ADDR;
            S_OUT:
                if (out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            size_cfg_reg <= CFG_W'(17);
            valid_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                size_cfg_reg <= cfg_wdata;
                valid_reg    <= '0;
            end
            else if (state_reg == S_IDLE && in_valid && in_data.kind == KIND_CLEAR)
                valid_reg <= '0;
            else if (ram_we)
                valid_reg[slot_reg[AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                kind_reg    <= in_data.kind;
                key_reg     <= in_data.key_value;
                quo_reg     <= in_data.key_value;
                size_reg    <= eff_size;
                rem_reg     <= '0;
                bit_cnt_reg <= 6'(KEY_W);
                pass_reg    <= 1'b0;
                probe_reg   <= '0;
                inc_reg     <= '0;
                if (in_data.kind == KIND_CLEAR)
                    res_reg <= '{status: ST_CLEARED, slot_index: 6'd0};
                else
                    res_reg <= '{status: ST_NOT_FOUND, slot_index: 6'd0};
            end
            S_DIV:
            begin
                if (bit_cnt_reg != 6'd0)
                begin
                    quo_reg <= {quo_reg[KEY_W-2:0], 1'b0};
                    if (trial >= {1'b0, divisor})
                        rem_reg <= SW'(trial - {1'b0, divisor});
                    else
                        rem_reg <= SW'(trial);
                    bit_cnt_reg <= bit_cnt_reg - 6'd1;
                end
                else
                begin
                    if (!pass_reg)
                    begin
                        step_reg    <= rem_reg + SW'(1);
                        quo_reg     <= key_reg;
                        rem_reg     <= '0;
                        bit_cnt_reg <= 6'(KEY_W);
                        pass_reg    <= 1'b1;
                    end
                    else
                        slot_reg <= rem_reg;
                end
            end
            S_CMP:
            begin
                if (!valid_reg[slot_reg[AW-1:0]])
                begin
                    if (kind_reg == KIND_INSERT)
                        res_reg <= '{status: ST_INSERTED, slot_index: 6'(slot_reg)};
                    else
                        res_reg <= '{status: ST_NOT_FOUND, slot_index: 6'd0};
                end
                else if (kind_reg == KIND_LOOKUP && rd_key == key_reg)
                    res_reg <= '{status: ST_FOUND, slot_index: 6'(slot_reg)};
                else if (kind_reg == KIND_INSERT)
                    res_reg <= '{status: ST_FULL, slot_index: 6'd0};
                else
                    res_reg <= '{status: ST_NOT_FOUND, slot_index: 6'd0};
                probe_reg <= probe_reg + SW'(1);
                // running (i * step) mod size for the next probe
                if ({1'b0, inc_reg} + {1'b0, step_reg} >= {1'b0, size_reg})
                    inc_reg <= SW'({1'b0, inc_reg} + {1'b0, step_reg}
                                   - {1'b0, size_reg});
                else
                    inc_reg <= inc_reg + step_reg;
            end
            S_NEXT:
            begin
                if (sum_w >= {1'b0, size_reg})
                    slot_reg <= SW'(sum_w - {1'b0, size_reg});
                else
                    slot_reg <= SW'(sum_w);
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = res_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result lost while stalled");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready)
        else $error("ready while busy");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> slot_reg < size_reg)
        else $error("slot outside table");

endmodule
